// File: sv/camac_nibble_link_codec_macros.svh
// Assertion macros for the nibble link codec checker
`ifndef CAMAC_NIBBLE_LINK_CODEC_MACROS_SVH
`define CAMAC_NIBBLE_LINK_CODEC_MACROS_SVH

// Check a property on every clock edge outside reset
`define CNLC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define CNLC_ASSERT_IMPL(label, cond, expr, msg) \
    `CNLC_ASSERT(label, (cond) |-> (expr), msg)

// Check that an antecedent implies a consequent in the next cycle
`define CNLC_ASSERT_NEXT(label, cond, expr, msg) \
    `CNLC_ASSERT(label, (cond) |=> (expr), msg)

`endif

// File: sv/cnlc_pkg.sv
`default_nettype none
package cnlc_pkg;

    localparam int MAX_STATIONS = 24;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [7:0] CODE_CAMAC = 8'd67;
    localparam logic [7:0] CODE_LAM   = 8'd76;
    localparam logic [7:0] CODE_INIT  = 8'd73;

    localparam logic OP_CMD   = 1'b0;
    localparam logic OP_REPLY = 1'b1;

    localparam logic [1:0] CK_CAMAC = 2'd0;
    localparam logic [1:0] CK_LAM   = 2'd1;
    localparam logic [1:0] CK_INIT  = 2'd2;

    localparam logic RK_TX     = 1'b0;
    localparam logic RK_ANSWER = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_ARG = 2'd1;
    localparam logic [1:0] ST_SHORT   = 2'd2;

    localparam logic [3:0] LONG_FRAME_LAST  = 4'd15;
    localparam logic [3:0] SHORT_FRAME_LAST = 4'd3;

    typedef struct packed {
        logic        is_answer;
        logic        long_frame;
        logic [7:0]  code;
        logic [2:0]  crate;
        logic [4:0]  station;
        logic [3:0]  sub;
        logic [4:0]  func;
        logic [23:0] wdata;
        logic [31:0] data;
        logic [1:0]  status;
    } t_job;

endpackage
`default_nettype wire

// File: sv/cnlc_front.sv
`default_nettype none
module cnlc_front
    import cnlc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic        i_operation,
    input  wire logic [1:0]  i_command_kind,
    input  wire logic [4:0]  i_station,
    input  wire logic [3:0]  i_subaddress,
    input  wire logic [4:0]  i_function_code,
    input  wire logic [23:0] i_write_data,
    input  wire logic [7:0]  i_reply_byte,
    input  wire logic        i_reply_end,
    input  wire logic        i_cfg_write,
    input  wire logic [2:0]  i_cfg_crate_select,
    output logic             o_push,
    output t_job             o_job
);

    typedef enum logic [2:0] {
        PEND_NONE,
        PEND_LONG,
        PEND_SHORT,
        PEND_LAM,
        PEND_INIT
    } t_pend;

    t_pend       r_pend, n_pend;
    logic [3:0]  r_prev, n_prev;
    logic        r_prev_valid, n_prev_valid;
    logic        r_marker, n_marker;
    logic [3:0]  r_count, n_count;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_crate_select;

    logic        crate_ok;
    logic        station_ok;
    logic [3:0]  nib;
    logic [31:0] acc_upd;
    logic [3:0]  count_upd;
    logic        done;

    function automatic logic [3:0] needed(t_pend k);
        unique case (k)
            PEND_LONG: return 4'd8;
            PEND_LAM:  return 4'd4;
            default:   return 4'd2;
        endcase
    endfunction

    function automatic logic [31:0] finish(t_pend k, logic [31:0] acc);
        logic [7:0] code;
        logic [4:0] bitpos;
        code   = acc[15:8];
        bitpos = 5'(code - 8'd1);
        priority if (k == PEND_LAM) begin
            if (code != 8'd0 && code <= 8'd32) return 32'd1 << bitpos;
            return 32'd0;
        end else if (k == PEND_LONG) begin
            return acc;
        end else begin
            return {24'd0, acc[7:0]};
        end
    endfunction

    assign crate_ok   = (r_crate_select != 3'd0);
    assign station_ok = ({1'b0, i_station} < 6'(MAX_STATIONS));
    assign nib        = i_reply_byte[3:0];

    always_comb begin
        n_pend       = r_pend;
        n_prev       = r_prev;
        n_prev_valid = r_prev_valid;
        n_marker     = r_marker;
        n_count      = r_count;
        n_acc        = r_acc;
        o_push       = 1'b0;
        o_job        = '0;
        o_job.crate  = r_crate_select;
        acc_upd      = r_acc;
        acc_upd[{r_count[2:0], 2'b00} +: 4] = nib;
        count_upd    = r_count + 4'd1;
        done         = 1'b0;
        if (i_accept) begin
            if (i_operation == OP_CMD) begin
                n_pend       = PEND_NONE;
                n_prev       = 4'd0;
                n_prev_valid = 1'b0;
                n_marker     = 1'b0;
                n_count      = 4'd0;
                n_acc        = 32'd0;
                o_push       = 1'b1;
                if (i_command_kind == CK_CAMAC && crate_ok && station_ok) begin
                    o_job.long_frame = 1'b1;
                    o_job.code       = CODE_CAMAC;
                    o_job.station    = i_station;
                    o_job.sub        = i_subaddress;
                    o_job.func       = i_function_code;
                    o_job.wdata      = i_write_data;
                    n_pend = (i_function_code > 5'd15) ? PEND_SHORT : PEND_LONG;
                end else if ((i_command_kind == CK_LAM || i_command_kind == CK_INIT)
                             && crate_ok) begin
                    o_job.code = (i_command_kind == CK_LAM) ? CODE_LAM : CODE_INIT;
                    n_pend     = (i_command_kind == CK_LAM) ? PEND_LAM : PEND_INIT;
                end else begin
                    o_job.is_answer = 1'b1;
                    o_job.status    = ST_BAD_ARG;
                end
            end else if (r_pend == PEND_NONE) begin
                if (i_reply_end) begin
                    n_prev       = 4'd0;
                    n_prev_valid = 1'b0;
                    n_marker     = 1'b0;
                    n_count      = 4'd0;
                    n_acc        = 32'd0;
                end
            end else begin
                if (!r_marker) begin
                    if (r_prev_valid && r_prev == 4'd3 && nib == 4'd4) begin
                        n_marker = 1'b1;
                        n_count  = 4'd0;
                        n_acc    = 32'd0;
                    end
                    n_prev       = nib;
                    n_prev_valid = 1'b1;
                end else if (count_upd >= needed(r_pend)) begin
                    done            = 1'b1;
                    o_push          = 1'b1;
                    o_job.is_answer = 1'b1;
                    o_job.data      = finish(r_pend, acc_upd);
                    o_job.status    = ST_OK;
                end else begin
                    n_acc   = acc_upd;
                    n_count = count_upd;
                end
                if (!done && i_reply_end) begin
                    o_push          = 1'b1;
                    o_job.is_answer = 1'b1;
                    o_job.status    = ST_SHORT;
                end
                if (done || i_reply_end) begin
                    n_pend       = PEND_NONE;
                    n_prev       = 4'd0;
                    n_prev_valid = 1'b0;
                    n_marker     = 1'b0;
                    n_count      = 4'd0;
                    n_acc        = 32'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend         <= PEND_NONE;
            r_prev         <= 4'd0;
            r_prev_valid   <= 1'b0;
            r_marker       <= 1'b0;
            r_count        <= 4'd0;
            r_acc          <= 32'd0;
            r_crate_select <= 3'd1;
        end else begin
            r_pend       <= n_pend;
            r_prev       <= n_prev;
            r_prev_valid <= n_prev_valid;
            r_marker     <= n_marker;
            r_count      <= n_count;
            r_acc        <= n_acc;
            if (i_cfg_write) begin
                r_crate_select <= i_cfg_crate_select;
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/cnlc_job_queue.sv
`default_nettype none
module cnlc_job_queue
    import cnlc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_job      o_job
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: sv/cnlc_back.sv
`default_nettype none
module cnlc_back
    import cnlc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_job_empty,
    input  t_job        i_job,
    output logic        o_job_pop,
    input  wire logic   i_pop,
    output logic        o_empty,
    output logic        o_result_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_frame_last,
    output logic [31:0] o_answer_data,
    output logic [1:0]  o_answer_status
);

    logic [3:0]  r_idx;
    logic        r_out_valid;
    logic        r_kind;
    logic [7:0]  r_tx;
    logic        r_last;
    logic [31:0] r_data;
    logic [1:0]  r_status;

    logic        load;
    logic        take;
    logic [7:0]  content;
    logic        last_byte;

    assign load = !r_out_valid || i_pop;
    assign take = load && !i_job_empty;

    always_comb begin
        unique case (r_idx[3:1])
            3'd0:    content = i_job.code;
            3'd1:    content = {5'd0, i_job.crate};
            3'd2:    content = {3'd0, i_job.station};
            3'd3:    content = {4'd0, i_job.sub};
            3'd4:    content = {3'd0, i_job.func};
            3'd5:    content = i_job.wdata[7:0];
            3'd6:    content = i_job.wdata[15:8];
            default: content = i_job.wdata[23:16];
        endcase
    end

    assign last_byte = i_job.long_frame ? (r_idx == LONG_FRAME_LAST)
                                        : (r_idx == SHORT_FRAME_LAST);
    assign o_job_pop = take && (i_job.is_answer || last_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 4'd0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= take;
            if (take) begin
                r_idx <= o_job_pop ? 4'd0 : r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (i_job.is_answer) begin
                r_kind   <= RK_ANSWER;
                r_tx     <= 8'd0;
                r_last   <= 1'b0;
                r_data   <= i_job.data;
                r_status <= i_job.status;
            end else begin
                r_kind   <= RK_TX;
                r_tx     <= r_idx[0] ? {content[7:4], 4'd0} : {content[3:0], 4'd0};
                r_last   <= last_byte;
                r_data   <= 32'd0;
                r_status <= ST_OK;
            end
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_result_kind   = r_kind;
    assign o_tx_byte       = r_tx;
    assign o_frame_last    = r_last;
    assign o_answer_data   = r_data;
    assign o_answer_status = r_status;

endmodule
`default_nettype wire

// File: sv/camac_nibble_link_codec.sv
// Host side of a nibble-serial CAMAC crate link. Items enter through a queue-style port
// (push/full) and results leave through one (empty/pop). A command item (camac action,
// LAM read, link init) becomes a frame of 16 or 4 transmit bytes, each content byte b
// sent as b<<4 then b&0xF0; a rejected command gives one answer with bad-argument status.
// Reply items are single received bytes: after the low-nibble marker 3,4 the block
// gathers 8, 4 or 2 nibbles and gives one answer, or a short-reply status if the
// transfer ends early. The front end takes one item per cycle unless the queue is full, and
// drops each command and each finished answer into a four-entry job queue; reply bytes
// that finish nothing leave no job. The back-end serializer emits one result per cycle
// while pop is held, so a camac action yields 16 results, a LAM read or init 4, and an
// answer 1; the first result of an item passes through the job queue and then the
// serializer's output register. Input stalls only while the job queue is full. The crate
// number is written on the configuration channel (always ready) and resets to 1.
`default_nettype none
module camac_nibble_link_codec
    import cnlc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_operation,
    input  wire logic [1:0]  i_command_kind,
    input  wire logic [4:0]  i_station,
    input  wire logic [3:0]  i_subaddress,
    input  wire logic [4:0]  i_function_code,
    input  wire logic [23:0] i_write_data,
    input  wire logic [7:0]  i_reply_byte,
    input  wire logic        i_reply_end,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_result_kind,
    output logic [7:0]       o_tx_byte,
    output logic             o_frame_last,
    output logic [31:0]      o_answer_data,
    output logic [1:0]       o_answer_status,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_crate_select
);

    t_job front_job;
    t_job head_job;
    logic front_push;
    logic q_empty;
    logic q_pop;
    logic accept;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    cnlc_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_operation        (i_operation),
        .i_command_kind     (i_command_kind),
        .i_station          (i_station),
        .i_subaddress       (i_subaddress),
        .i_function_code    (i_function_code),
        .i_write_data       (i_write_data),
        .i_reply_byte       (i_reply_byte),
        .i_reply_end        (i_reply_end),
        .i_cfg_write        (i_cfg_valid && o_cfg_ready),
        .i_cfg_crate_select (i_cfg_crate_select),
        .o_push             (front_push),
        .o_job              (front_job)
    );

    cnlc_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    cnlc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_empty     (q_empty),
        .i_job           (head_job),
        .o_job_pop       (q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_result_kind   (o_result_kind),
        .o_tx_byte       (o_tx_byte),
        .o_frame_last    (o_frame_last),
        .o_answer_data   (o_answer_data),
        .o_answer_status (o_answer_status)
    );

endmodule
`default_nettype wire

// File: sv/cnlc_checker.sv
`default_nettype none
`include "camac_nibble_link_codec_macros.svh"
module cnlc_checker
    import cnlc_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic        o_result_kind,
    input wire logic [7:0]  o_tx_byte,
    input wire logic        o_frame_last,
    input wire logic [31:0] o_answer_data,
    input wire logic [1:0]  o_answer_status
);

    logic        tx_shown;
    logic        answer_shown;
    logic        error_shown;
    logic        tx_clean;
    logic        answer_clean;
    logic        error_clean;
    logic [43:0] shown_res;

    assign tx_shown     = !empty && o_result_kind == RK_TX;
    assign answer_shown = !empty && o_result_kind == RK_ANSWER;
    assign error_shown  = !empty && o_answer_status != ST_OK;
    assign tx_clean     = o_answer_data == 32'd0 && o_answer_status == ST_OK
                          && o_tx_byte[3:0] == 4'd0;
    assign answer_clean = o_tx_byte == 8'd0 && !o_frame_last;
    assign error_clean  = o_answer_data == 32'd0 && o_answer_status <= ST_SHORT;
    assign shown_res    = {o_result_kind, o_tx_byte, o_frame_last, o_answer_data,
                           o_answer_status};

    `CNLC_ASSERT_IMPL(a_tx_clean, tx_shown, tx_clean, "transmit transaction carries answer fields")
    `CNLC_ASSERT_IMPL(a_answer_clean, answer_shown, answer_clean, "answer carries frame fields")
    `CNLC_ASSERT_IMPL(a_error_no_data, error_shown, error_clean, "error answer with data")
    `CNLC_ASSERT_NEXT(a_stall_hold, !empty && !pop, !empty && $stable(shown_res), "stall lost")

endmodule

bind camac_nibble_link_codec cnlc_checker u_cnlc_checker (.*);
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import cnlc_pkg::*;

    localparam logic [1:0] CK_UNKNOWN  = 2'd3;
    localparam logic [3:0] MARK_FIRST  = 4'h3;
    localparam logic [3:0] MARK_SECOND = 4'h4;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 300000;

    typedef enum logic [2:0] {
        REPLY_NONE, REPLY_LONG, REPLY_SHORT, REPLY_LAM, REPLY_INIT
    } t_wait;
    typedef enum logic [1:0] {POP_ALWAYS, POP_COIN, POP_PATTERN, POP_RARE} t_pop_mode;

    typedef struct packed {
        logic        op;
        logic [1:0]  kind;
        logic [4:0]  station;
        logic [3:0]  sub;
        logic [4:0]  func;
        logic [23:0] wdata;
        logic [7:0]  rbyte;
        logic        rend;
    } t_item;

    localparam int ITEM_W = $bits(t_item);

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx;
        logic        last;
        logic [31:0] data;
        logic [1:0]  status;
    } t_res;

    typedef struct packed {
        t_item it;
        logic  typed;
        t_res  res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n            = 1'b0;
    logic        push               = 1'b0;
    logic        full;
    logic        i_operation        = 1'b0;
    logic [1:0]  i_command_kind     = '0;
    logic [4:0]  i_station          = '0;
    logic [3:0]  i_subaddress       = '0;
    logic [4:0]  i_function_code    = '0;
    logic [23:0] i_write_data       = '0;
    logic [7:0]  i_reply_byte       = '0;
    logic        i_reply_end        = 1'b0;
    logic        empty;
    logic        pop                = 1'b0;
    logic        o_result_kind;
    logic [7:0]  o_tx_byte;
    logic        o_frame_last;
    logic [31:0] o_answer_data;
    logic [1:0]  o_answer_status;
    logic        i_cfg_valid        = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_crate_select = '0;

    camac_nibble_link_codec i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_operation        (i_operation),
        .i_command_kind     (i_command_kind),
        .i_station          (i_station),
        .i_subaddress       (i_subaddress),
        .i_function_code    (i_function_code),
        .i_write_data       (i_write_data),
        .i_reply_byte       (i_reply_byte),
        .i_reply_end        (i_reply_end),
        .empty              (empty),
        .pop                (pop),
        .o_result_kind      (o_result_kind),
        .o_tx_byte          (o_tx_byte),
        .o_frame_last       (o_frame_last),
        .o_answer_data      (o_answer_data),
        .o_answer_status    (o_answer_status),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_crate_select (i_cfg_crate_select)
    );

    // link state as the host side should track it
    t_wait       want;
    logic [2:0]  crate_reg;
    logic [3:0]  last_nib;
    logic        last_nib_ok;
    logic        synced;
    logic [3:0]  nib_cnt;
    logic [31:0] gathered;

    t_res awaited_results[$];
    t_row directed_rows[$];

    int mismatches    = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int answers_seen  = 0;
    int burst_left    = 0;
    int hold_requests = 0;
    int cycle_count   = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: timeout after %0d cycles", cycle_count);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic t_res answer(input logic [31:0] d, input logic [1:0] st);
        t_res r;
        r        = '0;
        r.kind   = RK_ANSWER;
        r.data   = d;
        r.status = st;
        return r;
    endfunction

    function automatic t_item cmd_item(input logic [1:0] kind, input logic [4:0] station,
                                       input logic [3:0] sub, input logic [4:0] func,
                                       input logic [23:0] wdata);
        t_item it;
        it         = '0;
        it.op      = OP_CMD;
        it.kind    = kind;
        it.station = station;
        it.sub     = sub;
        it.func    = func;
        it.wdata   = wdata;
        return it;
    endfunction

    function automatic t_item rx_item(input logic [7:0] b, input logic e);
        t_item it;
        it       = '0;
        it.op    = OP_REPLY;
        it.rbyte = b;
        it.rend  = e;
        return it;
    endfunction

    function automatic void add_row(input t_item it, input logic typed, input t_res res);
        t_row row;
        row.it    = it;
        row.typed = typed;
        row.res   = res;
        directed_rows.push_back(row);
    endfunction

    task automatic clear_hunt();
        last_nib    = '0;
        last_nib_ok = 1'b0;
        synced      = 1'b0;
        nib_cnt     = '0;
        gathered    = '0;
    endtask

    task automatic compute_link_results(input t_item it);
        logic [7:0]  body [8];
        int          len;
        int          need;
        logic [3:0]  nib;
        logic [7:0]  code;
        logic [31:0] data;
        logic        accepted_cmd;
        t_res        r;
        if (it.op == OP_CMD) begin
            want = REPLY_NONE;
            clear_hunt();
            accepted_cmd = crate_reg != 0 &&
                ((it.kind == CK_CAMAC && it.station < MAX_STATIONS) ||
                 it.kind == CK_LAM || it.kind == CK_INIT);
            if (!accepted_cmd) begin
                awaited_results.push_back(answer('0, ST_BAD_ARG));
                return;
            end
            body[0] = (it.kind == CK_CAMAC) ? CODE_CAMAC :
                      (it.kind == CK_LAM) ? CODE_LAM : CODE_INIT;
            body[1] = {5'b0, crate_reg};
            body[2] = {3'b0, it.station};
            body[3] = {4'b0, it.sub};
            body[4] = {3'b0, it.func};
            body[5] = it.wdata[7:0];
            body[6] = it.wdata[15:8];
            body[7] = it.wdata[23:16];
            len = (it.kind == CK_CAMAC) ? 8 : 2;
            if (it.kind == CK_CAMAC)
                want = (it.func > 15) ? REPLY_SHORT : REPLY_LONG;
            else
                want = (it.kind == CK_LAM) ? REPLY_LAM : REPLY_INIT;
            for (int i = 0; i < len; i++) begin
                r      = '0;
                r.kind = RK_TX;
                r.tx   = {body[i][3:0], 4'h0};
                awaited_results.push_back(r);
                r.tx   = body[i] & 8'hF0;
                r.last = (i == len - 1);
                awaited_results.push_back(r);
            end
            return;
        end

        if (want == REPLY_NONE) begin
            if (it.rend)
                clear_hunt();
            return;
        end

        nib = it.rbyte[3:0];
        if (!synced) begin
            if (last_nib_ok && last_nib == MARK_FIRST && nib == MARK_SECOND) begin
                synced   = 1'b1;
                nib_cnt  = '0;
                gathered = '0;
            end
            last_nib    = nib;
            last_nib_ok = 1'b1;
        end else begin
            gathered = gathered | (32'(nib) << (4 * nib_cnt));
            nib_cnt  = nib_cnt + 1'b1;
            need = (want == REPLY_LONG) ? 8 : (want == REPLY_LAM) ? 4 : 2;
            if (nib_cnt >= need) begin
                if (want == REPLY_LAM) begin
                    code = gathered[15:8];
                    data = (code >= 1 && code <= 32) ? (32'd1 << (code - 1)) : 32'd0;
                end else if (want == REPLY_LONG) begin
                    data = gathered;
                end else begin
                    data = {24'b0, gathered[7:0]};
                end
                want = REPLY_NONE;
                clear_hunt();
                awaited_results.push_back(answer(data, ST_OK));
                return;
            end
        end

        if (it.rend) begin
            want = REPLY_NONE;
            clear_hunt();
            awaited_results.push_back(answer('0, ST_SHORT));
        end
    endtask

    task automatic report_mismatch(input string what, input t_res want_r, input t_res got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("tb_top: %s at cycle %0d: expected kind %0d tx %02h last %0d data %08h st %0d",
                     what, cycle_count, want_r.kind, want_r.tx, want_r.last, want_r.data,
                     want_r.status);
            $display("tb_top:   got kind %0d tx %02h last %0d data %08h st %0d",
                     got.kind, got.tx, got.last, got.data, got.status);
        end
    endtask

    task automatic send_item(input t_item it, input logic typed, input t_res typed_res);
        push            <= 1'b1;
        i_operation     <= it.op;
        i_command_kind  <= it.kind;
        i_station       <= it.station;
        i_subaddress    <= it.sub;
        i_function_code <= it.func;
        i_write_data    <= it.wdata;
        i_reply_byte    <= it.rbyte;
        i_reply_end     <= it.rend;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        compute_link_results(it);
        if (typed)
            awaited_results[awaited_results.size() - 1] = typed_res;
        items_sent++;
        if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain_and_settle();
        push <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_crate(input logic [2:0] value);
        i_cfg_crate_select <= value;
        i_cfg_valid        <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        crate_reg = value;
    endtask

    task automatic send_exchange(output int counted);
        t_item      it;
        logic [7:0] rx [$];
        logic [3:0] nib;
        logic [7:0] code;
        int         pick;
        int         need;
        int         given;
        logic       cut;
        logic       rejected;
        counted    = 0;
        pick       = $urandom_range(0, 99);
        it.op      = OP_CMD;
        it.kind    = (pick < 45) ? CK_CAMAC : (pick < 70) ? CK_LAM :
                     (pick < 95) ? CK_INIT : CK_UNKNOWN;
        it.station = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(MAX_STATIONS, 31)) :
                                                   5'($urandom_range(0, MAX_STATIONS - 1));
        it.sub     = 4'($urandom);
        it.func    = 5'($urandom);
        it.wdata   = 24'($urandom);
        it.rbyte   = 8'($urandom);
        it.rend    = 1'($urandom);
        rejected = crate_reg == 0 || it.kind == CK_UNKNOWN ||
                   (it.kind == CK_CAMAC && it.station >= MAX_STATIONS);
        send_item(it, 1'b0, '0);
        counted = 1;
        // leave some requests open so the next command drops them
        if (rejected || $urandom_range(0, 9) == 0)
            return;

        need = (it.kind == CK_CAMAC) ? ((it.func > 15) ? 2 : 8) :
               (it.kind == CK_LAM) ? 4 : 2;
        cut  = ($urandom_range(0, 6) == 0);
        repeat ($urandom_range(0, 3)) rx.push_back(8'($urandom));
        if (!(cut && $urandom_range(0, 1) == 0)) begin
            rx.push_back({4'($urandom), MARK_FIRST});
            rx.push_back({4'($urandom), MARK_SECOND});
        end
        given = cut ? $urandom_range(0, need - 1) : need + $urandom_range(0, 2);
        code  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 33));
        for (int i = 0; i < given; i++) begin
            nib = 4'($urandom);
            if (it.kind == CK_LAM && i == 2)
                nib = code[3:0];
            if (it.kind == CK_LAM && i == 3)
                nib = code[7:4];
            rx.push_back({4'($urandom), nib});
        end
        for (int i = 0; i < rx.size(); i++) begin
            it       = t_item'(ITEM_W'({$urandom, $urandom}));
            it.op    = OP_REPLY;
            it.rbyte = rx[i];
            it.rend  = (i == rx.size() - 1);
            send_item(it, 1'b0, '0);
            counted++;
        end
    endtask

    // result side: check each transaction, then pick the next pop
    t_pop_mode pop_mode   = POP_ALWAYS;
    int        rx_cycles  = 0;
    int        hold_left  = 0;
    int        hold_taken = 0;

    always @(posedge i_clk) begin
        t_res got;
        t_res head;
        if (i_rst_n && pop && !empty) begin
            got.kind   = o_result_kind;
            got.tx     = o_tx_byte;
            got.last   = o_frame_last;
            got.data   = o_answer_data;
            got.status = o_answer_status;
            results_seen++;
            if (got.kind == RK_ANSWER)
                answers_seen++;
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                head = awaited_results.pop_front();
                if (got !== head)
                    report_mismatch("mismatch", head, got);
            end
        end
        rx_cycles++;
        if (hold_taken != hold_requests) begin
            hold_taken = hold_requests;
            hold_left  = HOLD_CYCLES;
        end
        if (rx_cycles % 64 == 0)
            pop_mode = t_pop_mode'($urandom_range(0, 3));
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            case (pop_mode)
                POP_ALWAYS:  pop <= 1'b1;
                POP_COIN:    pop <= 1'($urandom);
                POP_PATTERN: pop <= (rx_cycles % 8) >= 3;
                default:     pop <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    int crate_plan [5] = '{7, 0, 4, 1, 2};
    int item_plan  [5] = '{75, 20, 75, 75, 75};

    initial begin
        int    n;
        int    done_items;
        t_item it;
        crate_reg = 3'd1;
        want      = REPLY_NONE;
        clear_hunt();

        add_row(rx_item(8'hFF, 1'b1), 1'b0, '0);
        add_row(cmd_item(CK_CAMAC, 5'd0, 4'd0, 5'd0, 24'h000000), 1'b0, '0);
        add_row(rx_item(8'h13, 1'b0), 1'b0, '0);
        add_row(rx_item(8'hF4, 1'b0), 1'b0, '0);
        for (int i = 1; i < 8; i++)
            add_row(rx_item({4'(16 - i), 4'(i)}, 1'b0), 1'b0, '0);
        add_row(rx_item(8'h88, 1'b0), 1'b1, answer(32'h8765_4321, ST_OK));
        add_row(cmd_item(CK_LAM, 5'd0, 4'd0, 5'd0, 24'h000000), 1'b0, '0);
        add_row(rx_item(8'h03, 1'b0), 1'b0, '0);
        add_row(rx_item(8'h04, 1'b0), 1'b0, '0);
        add_row(rx_item(8'h00, 1'b0), 1'b0, '0);
        add_row(rx_item(8'h00, 1'b0), 1'b0, '0);
        add_row(rx_item(8'h00, 1'b0), 1'b0, '0);
        add_row(rx_item(8'h02, 1'b0), 1'b1, answer(32'h8000_0000, ST_OK));
        add_row(cmd_item(CK_CAMAC, 5'd23, 4'd15, 5'd31, 24'hFFFFFF), 1'b0, '0);
        add_row(cmd_item(CK_INIT, 5'd31, 4'd15, 5'd31, 24'hFFFFFF), 1'b0, '0);
        add_row(rx_item(8'h03, 1'b1), 1'b1, answer('0, ST_SHORT));
        add_row(cmd_item(CK_CAMAC, 5'd24, 4'd0, 5'd0, 24'h000000), 1'b1, answer('0, ST_BAD_ARG));
        add_row(cmd_item(CK_CAMAC, 5'd31, 4'd15, 5'd31, 24'hFFFFFF), 1'b1,
                answer('0, ST_BAD_ARG));
        add_row(cmd_item(CK_UNKNOWN, 5'd0, 4'd0, 5'd0, 24'h000000), 1'b1,
                answer('0, ST_BAD_ARG));
        add_row(rx_item(8'h34, 1'b0), 1'b0, '0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_item(directed_rows[r].it, directed_rows[r].typed, directed_rows[r].res);

        foreach (crate_plan[p]) begin
            drain_and_settle();
            write_crate(3'(crate_plan[p]));
            if (p == 2)
                hold_requests++;
            done_items = 0;
            while (done_items < item_plan[p]) begin
                send_exchange(n);
                done_items += n;
                if ($urandom_range(0, 9) == 0) begin
                    it = rx_item(8'($urandom), 1'($urandom));
                    send_item(it, 1'b0, '0);
                end
            end
        end

        drain_and_settle();
        $display("tb_top: %0d items pushed, %0d results popped (%0d answers), %0d mismatches",
                 items_sent, results_seen, answers_seen, mismatches);
        $display("tb_top: crate settings 1,7,0,4,1,2 with one %0d-cycle output stall",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
